@@ design/slbe_pkg.sv @@
// Shared types, codes and cell/readout functions for the scanline line buffer.
`default_nettype none

package slbe_pkg;

    // Default number of line entries
    localparam int LINE_ENTRIES_DEFAULT = 160;

    // Command codes
    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_HEADER  = 2'd1,
        CMD_GRAPHIC = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam logic CFG_KANGAROO  = 1'b0;
    localparam logic CFG_READ_MODE = 1'b1;

    // Readout formats
    localparam logic [1:0] RM_WIDE  = 2'd0;
    localparam logic [1:0] RM_NONE  = 2'd1;
    localparam logic [1:0] RM_HIRES = 2'd2;
    localparam logic [1:0] RM_HIRES_B = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CELLS,
        ST_READ
    } state_t;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic       kangaroo;
        logic [1:0] read_mode;
    } cfg_t;

    // Line memory access request
    typedef struct packed {
        logic       clear;
        logic       wr_en;
        logic [7:0] wr_addr;
        logic [4:0] wr_data;
        logic       rd_en;
        logic [7:0] rd_addr;
    } ram_req_t;

    // Extract cell idx of a graphic byte
    function automatic logic [3:0] cell_code(input logic [7:0] b, input logic mode,
                                             input logic [1:0] idx);
        logic [3:0] c;
        c = 4'd0;
        if (mode) begin
            if (!idx[0])
                c = {b[3:2], b[7:6]};
            else
                c = {b[1:0], b[5:4]};
        end else begin
            case (idx)
                2'd0:    c = {2'b00, b[7:6]};
                2'd1:    c = {2'b00, b[5:4]};
                2'd2:    c = {2'b00, b[3:2]};
                default: c = {2'b00, b[1:0]};
            endcase
        end
        return c;
    endfunction

    // Build the entry value written for a nonzero cell
    function automatic logic [4:0] entry_value(input logic [3:0] c, input logic [2:0] pal,
                                               input logic mode);
        return mode ? {pal[2], c} : {pal, c[1:0]};
    endfunction

    // Map a value with empty low bits to background
    function automatic logic [4:0] color_of(input logic [4:0] v);
        return (v[1:0] != 2'b00) ? v : 5'd0;
    endfunction

    // Turn one entry into {left, right} colour indices
    function automatic logic [9:0] readout_map(input logic [4:0] e, input logic [1:0] rm);
        logic [4:0] l;
        logic [4:0] r;
        case (rm)
            RM_HIRES:
            begin
                l = {e[4], 2'b00, e[1], e[3]};
                r = {e[4], 2'b00, e[0], e[2]};
            end
            RM_HIRES_B:
            begin
                l = {e[4:1], 1'b0};
                r = {e[4:2], e[0], 1'b0};
            end
            default:
            begin
                l = e;
                r = e;
            end
        endcase
        return {color_of(l), color_of(r)};
    endfunction

endpackage

`default_nettype wire

@@ design/slbe_line_ram.sv @@
// Line entry memory with per-entry valid bits and a registered read port.
`default_nettype none

module slbe_line_ram #(
    parameter int LINE_ENTRIES = slbe_pkg::LINE_ENTRIES_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire slbe_pkg::ram_req_t req,
    output logic [4:0]              rd_entry
);
    import slbe_pkg::*;

    localparam int AW = (LINE_ENTRIES > 1) ? $clog2(LINE_ENTRIES) : 1;
    localparam logic [8:0] LIMIT = 9'(LINE_ENTRIES);

    logic [4:0]              mem [LINE_ENTRIES];
    logic [LINE_ENTRIES-1:0] valid_reg;
    logic [4:0]              rd_data_reg;
    logic                    rd_hit_reg;
    logic                    wr_in_range;
    logic                    rd_in_range;
    logic [AW-1:0]           wr_idx;
    logic [AW-1:0]           rd_idx;

    // Decode addresses against the store depth
    assign wr_in_range = ({1'b0, req.wr_addr} < LIMIT);
    assign rd_in_range = ({1'b0, req.rd_addr} < LIMIT);
    assign wr_idx      = req.wr_addr[AW-1:0];
    assign rd_idx      = req.rd_addr[AW-1:0];

    // Write the entry array
    always_ff @(posedge clk)
    begin
        if (req.wr_en && wr_in_range)
            mem[wr_idx] <= req.wr_data;
    end

    // Clear all valid bits at once, set on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (req.clear)
            valid_reg <= '0;
        else if (req.wr_en && wr_in_range)
            valid_reg[wr_idx] <= 1'b1;
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
            rd_data_reg <= mem[rd_idx];
    end

    // Register whether the read hit a written entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_hit_reg <= 1'b0;
        else if (req.rd_en)
            rd_hit_reg <= rd_in_range && valid_reg[rd_idx];
    end

    // Unwritten or out-of-range entries read as zero
    assign rd_entry = rd_hit_reg ? rd_data_reg : 5'd0;

endmodule

`default_nettype wire

@@ design/slbe_ctrl.sv @@
// Command sequencer: object header state, cell writes and read issue.
`default_nettype none

module slbe_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         cmd,
    input  wire logic [7:0]         graphic_byte,
    input  wire logic [15:0]        graphic_address,
    input  wire logic               holey_8,
    input  wire logic               holey_16,
    input  wire logic [2:0]         object_palette,
    input  wire logic [7:0]         object_hpos,
    input  wire logic               object_write_mode,
    input  wire logic               update_write_mode,
    input  wire logic [7:0]         entry_index,
    input  wire slbe_pkg::cfg_t     cfg,
    input  wire logic               out_free,
    output slbe_pkg::ram_req_t      req,
    output logic                    out_load
);
    import slbe_pkg::*;

    state_t     state_reg, state_next;
    logic [7:0] pos_reg, pos_next;
    logic [2:0] palette_reg, palette_next;
    logic       wmode_reg, wmode_next;
    logic [7:0] byte_reg, byte_next;
    logic [1:0] cnt_reg, cnt_next;

    logic       accept;
    logic       holey;
    logic [7:0] masked_byte;
    logic [7:0] src_byte;
    logic [1:0] src_idx;
    logic [3:0] cur_cell;
    logic       do_cell;
    logic       last_cell;

    assign accept = in_valid && (state_reg == ST_IDLE);

    // Zero the byte on holey addresses
    assign holey = graphic_address[15] &&
                   ((holey_16 && graphic_address[12]) || (holey_8 && graphic_address[11]));
    assign masked_byte = holey ? 8'd0 : graphic_byte;

    // Select the cell being written this cycle
    assign src_byte  = (state_reg == ST_CELLS) ? byte_reg : masked_byte;
    assign src_idx   = (state_reg == ST_CELLS) ? cnt_reg : 2'd0;
    assign cur_cell  = cell_code(src_byte, wmode_reg, src_idx);
    assign do_cell   = (accept && (cmd == CMD_GRAPHIC)) || (state_reg == ST_CELLS);
    assign last_cell = (src_idx == (wmode_reg ? 2'd1 : 2'd3));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_GRAPHIC))
                    state_next = ST_CELLS;
                else if (accept && (cmd == CMD_READ) && (cfg.read_mode != RM_NONE))
                    state_next = ST_READ;
            end
            ST_CELLS:
            begin
                if (last_cell)
                    state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        out_load     = (state_reg == ST_READ) && out_free;
        req.clear    = accept && (cmd == CMD_CLEAR);
        req.wr_en    = do_cell && ((cur_cell != 4'd0) || cfg.kangaroo);
        req.wr_addr  = pos_reg;
        req.wr_data  = (cur_cell != 4'd0) ? entry_value(cur_cell, palette_reg, wmode_reg)
                                          : 5'd0;
        req.rd_en    = accept && (cmd == CMD_READ);
        req.rd_addr  = entry_index;
    end

    // Header state, position and cell counter
    always_comb
    begin
        pos_next     = pos_reg;
        palette_next = palette_reg;
        wmode_next   = wmode_reg;
        byte_next    = byte_reg;
        cnt_next     = cnt_reg;
        if (accept && (cmd == CMD_HEADER))
        begin
            palette_next = object_palette;
            pos_next     = object_hpos;
            if (update_write_mode)
                wmode_next = object_write_mode;
        end
        if (do_cell)
            pos_next = pos_reg + 8'd1;
        if (accept && (cmd == CMD_GRAPHIC))
        begin
            byte_next = masked_byte;
            cnt_next  = 2'd1;
        end
        else if (state_reg == ST_CELLS)
            cnt_next = cnt_reg + 2'd1;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= 8'd0;
            palette_reg <= 3'd0;
            wmode_reg   <= 1'b0;
            cnt_reg     <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            palette_reg <= palette_next;
            wmode_reg   <= wmode_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Hold the graphic byte
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

`default_nettype wire

@@ design/scanline_line_buffer_engine.sv @@
// Scanline line buffer: top level with configuration and result registers.
//
// Usage:
//   Input beats (in_valid/in_ready) carry one command each: clear store,
//   object header, graphic byte or read entry. Result beats
//   (out_valid/out_ready) carry a pair of colour register indices, one for
//   each read entry command when read_mode is not 1.
//   Clear and header complete as they are accepted. A graphic byte covers
//   four cells in write mode 0 and two in write mode 1: one cell is written
//   to the line memory per cycle through its single write port. A read first
//   reads the memory, then loads the result register once it is free;
//   out_valid rises as the result register is loaded. Clear acts on the
//   whole store at once because each entry carries a valid bit in flops
//   that clear resets together. Reset empties the line store, zeroes
//   position, palette, write mode and both configuration registers, and
//   drops any pending result. A stalled receiver holds the result
//   register; other commands are still taken, but a further read blocks
//   the input until that register frees. The user writes configuration
//   (cfg_we, cfg_addr, cfg_wdata) only while idle; the block does not check.
`default_nettype none

module scanline_line_buffer_engine #(
    parameter int LINE_ENTRIES = slbe_pkg::LINE_ENTRIES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [1:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  graphic_byte,
    input  wire logic [15:0] graphic_address,
    input  wire logic        holey_8,
    input  wire logic        holey_16,
    input  wire logic [2:0]  object_palette,
    input  wire logic [7:0]  object_hpos,
    input  wire logic        object_write_mode,
    input  wire logic        update_write_mode,
    input  wire logic [7:0]  entry_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       left_color_index,
    output logic [4:0]       right_color_index
);
    import slbe_pkg::*;

    cfg_t       cfg;
    ram_req_t   req;
    logic [4:0] rd_entry;
    logic       out_load;
    logic       out_free;
    logic       kangaroo_reg;
    logic [1:0] read_mode_reg;
    logic       out_valid_reg;
    logic [9:0] pair_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kangaroo_reg  <= 1'b0;
            read_mode_reg <= RM_WIDE;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_KANGAROO:  kangaroo_reg  <= cfg_wdata[0];
                CFG_READ_MODE: read_mode_reg <= cfg_wdata;
                default:       kangaroo_reg  <= kangaroo_reg;
            endcase
        end
    end

    assign cfg.kangaroo  = kangaroo_reg;
    assign cfg.read_mode = read_mode_reg;

    slbe_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .cmd               (cmd),
        .graphic_byte      (graphic_byte),
        .graphic_address   (graphic_address),
        .holey_8           (holey_8),
        .holey_16          (holey_16),
        .object_palette    (object_palette),
        .object_hpos       (object_hpos),
        .object_write_mode (object_write_mode),
        .update_write_mode (update_write_mode),
        .entry_index       (entry_index),
        .cfg               (cfg),
        .out_free          (out_free),
        .req               (req),
        .out_load          (out_load)
    );

    slbe_line_ram #(
        .LINE_ENTRIES (LINE_ENTRIES)
    ) u_line_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rd_entry (rd_entry)
    );

    // Result register is free when empty or being taken
    assign out_free = !out_valid_reg || out_ready;

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Map the read entry into the result pair
    always_ff @(posedge clk)
    begin
        if (out_load)
            pair_reg <= readout_map(rd_entry, read_mode_reg);
    end

    assign out_valid         = out_valid_reg;
    assign left_color_index  = pair_reg[9:5];
    assign right_color_index = pair_reg[4:0];

endmodule

`default_nettype wire

@@ verif/tb_scanline_line_buffer_engine.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the scanline line buffer engine.

module tb_scanline_line_buffer_engine;
    import slbe_pkg::*;

    localparam int ENTRIES       = 160;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 12;

    // One command beat as it appears on the input ports
    typedef struct packed {
        cmd_t        op;
        logic [7:0]  gbyte;
        logic [15:0] gaddr;
        logic        h8;
        logic        h16;
        logic [2:0]  pal;
        logic [7:0]  hpos;
        logic        wmode;
        logic        upd;
        logic [7:0]  index;
    } beat_t;

    // Tracks line contents and the colour pairs each read should return
    class pixel_pair_board;
        logic [4:0] line_copy [ENTRIES];
        logic [7:0] draw_pos;
        logic [2:0] pal_now;
        logic       wmode_now;
        logic       kangaroo;
        logic [1:0] readout;
        logic [9:0] pending_pixels [$];
        int         errors;

        function new();
            wipe();
            draw_pos  = 8'd0;
            pal_now   = 3'd0;
            wmode_now = 1'b0;
            kangaroo  = 1'b0;
            readout   = RM_WIDE;
            errors    = 0;
        endfunction

        function void wipe();
            foreach (line_copy[i])
                line_copy[i] = 5'd0;
        endfunction

        function void set_register(logic idx, logic [1:0] val);
            if (idx == CFG_KANGAROO)
                kangaroo = val[0];
            else
                readout = val;
        endfunction

        // Write one cell at the draw position, then advance with 8-bit wrap
        function void place(logic [3:0] code, logic [4:0] value);
            if (draw_pos < ENTRIES)
            begin
                if (code != 4'd0)
                    line_copy[draw_pos] = value;
                else if (kangaroo)
                    line_copy[draw_pos] = 5'd0;
            end
            draw_pos = draw_pos + 8'd1;
        endfunction

        function logic [4:0] shade(logic [4:0] v);
            return (v[1:0] != 2'b00) ? v : 5'd0;
        endfunction

        function void take_command(beat_t b);
            logic [7:0] data;
            logic [3:0] c0;
            logic [3:0] c1;
            logic [4:0] e;
            logic [4:0] l;
            logic [4:0] r;
            logic       holey;
            int         k;
            case (b.op)
                CMD_CLEAR:
                    wipe();
                CMD_HEADER:
                begin
                    pal_now  = b.pal;
                    draw_pos = b.hpos;
                    if (b.upd)
                        wmode_now = b.wmode;
                end
                CMD_GRAPHIC:
                begin
                    holey = b.gaddr[15] && ((b.h16 && b.gaddr[12]) || (b.h8 && b.gaddr[11]));
                    data  = holey ? 8'd0 : b.gbyte;
                    if (wmode_now)
                    begin
                        c0 = {data[3:2], data[7:6]};
                        c1 = {data[1:0], data[5:4]};
                        place(c0, {pal_now[2], c0});
                        place(c1, {pal_now[2], c1});
                    end
                    else
                    begin
                        for (k = 0; k < 4; k++)
                        begin
                            c0 = {2'b00, data[7 - 2 * k -: 2]};
                            place(c0, {pal_now, c0[1:0]});
                        end
                    end
                end
                default:
                begin
                    e = (b.index < ENTRIES) ? line_copy[b.index] : 5'd0;
                    case (readout)
                        RM_HIRES:
                        begin
                            l = (e & 5'h10) | ((e >> 3) & 5'h01) | (e & 5'h02);
                            r = (e & 5'h10) | ((e >> 2) & 5'h01) | ((e & 5'h01) << 1);
                        end
                        RM_HIRES_B:
                        begin
                            l = e & 5'h1e;
                            r = (e & 5'h1c) | ((e & 5'h01) << 1);
                        end
                        default:
                        begin
                            l = e;
                            r = e;
                        end
                    endcase
                    if (readout != RM_NONE)
                        pending_pixels.push_back({shade(l), shade(r)});
                end
            endcase
        endfunction

        function void check_pixels(logic [4:0] left_got, logic [4:0] right_got);
            logic [9:0] want;
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected result beat: left %0d right %0d", left_got, right_got);
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (left_got !== want[9:5])
                begin
                    $error("left_color_index: expected %0d, got %0d", want[9:5], left_got);
                    errors++;
                end
                if (right_got !== want[4:0])
                begin
                    $error("right_color_index: expected %0d, got %0d", want[4:0], right_got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_addr;
    logic [1:0] cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic       out_valid;
    logic       out_ready;
    logic [4:0] left_color_index;
    logic [4:0] right_color_index;
    beat_t      driven;

    pixel_pair_board board;
    int              beats_sent;
    int              idle_cycles;
    bit              calm_in;
    bit              calm_out;

    scanline_line_buffer_engine uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .cmd               (driven.op),
        .graphic_byte      (driven.gbyte),
        .graphic_address   (driven.gaddr),
        .holey_8           (driven.h8),
        .holey_16          (driven.h16),
        .object_palette    (driven.pal),
        .object_hpos       (driven.hpos),
        .object_write_mode (driven.wmode),
        .update_write_mode (driven.upd),
        .entry_index       (driven.index),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .left_color_index  (left_color_index),
        .right_color_index (right_color_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watch both channels: note input beats, check result beats, catch hangs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.take_command(driven);
            if (out_valid && out_ready)
                board.check_pixels(left_color_index, right_color_index);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL scanline_line_buffer_engine");
                $finish;
            end
        end
    end

    // Accept results with a random stall before each beat
    initial
    begin : result_sink
        int stall;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = calm_out ? 0 : $urandom_range(4, 0);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    function automatic beat_t command_beat(cmd_t op);
        beat_t b;
        b.op    = op;
        b.gbyte = 8'($urandom_range(255, 0));
        b.gaddr = 16'($urandom_range(65535, 0));
        b.h8    = 1'($urandom_range(1, 0));
        b.h16   = 1'($urandom_range(1, 0));
        b.pal   = 3'($urandom_range(7, 0));
        b.hpos  = 8'($urandom_range(255, 0));
        b.wmode = 1'($urandom_range(1, 0));
        b.upd   = 1'($urandom_range(1, 0));
        b.index = 8'($urandom_range(255, 0));
        return b;
    endfunction

    // Present one beat after a random gap and hold it until accepted
    task automatic send_beat(input beat_t b);
        int gap;
        gap = calm_in ? 0 : $urandom_range(4, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        driven   <= b;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
    endtask

    task automatic send_clear();
        send_beat(command_beat(CMD_CLEAR));
    endtask

    task automatic send_header(input logic [2:0] pal, input logic [7:0] hpos,
                               input logic wmode, input logic upd);
        beat_t b;
        b       = command_beat(CMD_HEADER);
        b.pal   = pal;
        b.hpos  = hpos;
        b.wmode = wmode;
        b.upd   = upd;
        send_beat(b);
    endtask

    task automatic send_graphic(input logic [7:0] gbyte, input logic [15:0] gaddr,
                                input logic h8, input logic h16);
        beat_t b;
        b       = command_beat(CMD_GRAPHIC);
        b.gbyte = gbyte;
        b.gaddr = gaddr;
        b.h8    = h8;
        b.h16   = h16;
        send_beat(b);
    endtask

    task automatic send_read(input logic [7:0] index);
        beat_t b;
        b       = command_beat(CMD_READ);
        b.index = index;
        send_beat(b);
    endtask

    // Drop valid and wait until every result is in and the block is quiet
    task automatic settle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (board.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic kang, input logic [1:0] rm);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_KANGAROO;
        cfg_wdata <= {1'b0, kang};
        @(posedge clk);
        cfg_addr  <= CFG_READ_MODE;
        cfg_wdata <= rm;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_register(CFG_KANGAROO, {1'b0, kang});
        board.set_register(CFG_READ_MODE, rm);
    endtask

    // Mostly draw an object and read around it; mix in clears and noise
    task automatic run_random(input int count);
        int         stop;
        int         pick;
        logic [7:0] origin;
        stop = beats_sent + count;
        while (beats_sent < stop)
        begin
            calm_in  = ($urandom_range(3, 0) == 0);
            calm_out = ($urandom_range(3, 0) == 0);
            pick     = $urandom_range(11, 0);
            if (pick < 7)
            begin
                origin = 8'(($urandom_range(3, 0) == 0) ? $urandom_range(255, 0)
                                                        : $urandom_range(ENTRIES - 1, 0));
                send_header(3'($urandom_range(7, 0)), origin, 1'($urandom_range(1, 0)),
                            1'($urandom_range(1, 0)));
                repeat ($urandom_range(5, 1))
                    send_graphic(8'($urandom_range(255, 0)), 16'($urandom_range(65535, 0)),
                                 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
                repeat ($urandom_range(4, 1))
                    send_read(origin + 8'($urandom_range(15, 0)));
            end
            else if (pick == 7)
                send_clear();
            else if (pick < 10)
                send_read(8'(($urandom_range(3, 0) == 0) ? $urandom_range(255, 0)
                                                         : $urandom_range(ENTRIES - 1, 0)));
            else
                send_beat(command_beat(cmd_t'($urandom_range(3, 0))));
        end
    endtask

    initial
    begin : stimulus
        int p;
        board       = new();
        beats_sent  = 0;
        calm_in     = 1'b0;
        calm_out    = 1'b0;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_addr    <= CFG_KANGAROO;
        cfg_wdata   <= 2'd0;
        in_valid    <= 1'b0;
        driven      <= '0;
        idle_cycles <= 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: cell order, transparency, store end, wrap, holey tests
        write_config(1'b0, RM_WIDE);
        send_clear();
        send_header(3'd7, 8'd0, 1'b0, 1'b1);
        send_graphic(8'h1b, 16'h0000, 1'b0, 1'b0);
        send_graphic(8'hff, 16'hffff, 1'b0, 1'b0);
        send_header(3'd4, 8'd158, 1'b1, 1'b1);
        send_graphic(8'he4, 16'h1234, 1'b1, 1'b1);
        send_graphic(8'hff, 16'h0000, 1'b0, 1'b0);
        send_header(3'd2, 8'd254, 1'b0, 1'b0);
        send_graphic(8'hff, 16'h0000, 1'b0, 1'b0);
        send_header(3'd5, 8'd4, 1'b0, 1'b1);
        send_graphic(8'hff, 16'h8800, 1'b1, 1'b0);
        send_graphic(8'h55, 16'h9000, 1'b0, 1'b1);
        send_graphic(8'h55, 16'h1800, 1'b1, 1'b1);
        send_read(8'd0);
        send_read(8'd1);
        send_read(8'd5);
        send_read(8'd159);
        send_read(8'd160);
        send_read(8'd255);
        send_clear();
        send_read(8'd1);
        settle();

        // Directed: kangaroo clearing and the other readout formats
        write_config(1'b1, RM_HIRES);
        send_header(3'd3, 8'd0, 1'b0, 1'b1);
        send_graphic(8'hff, 16'h0000, 1'b0, 1'b0);
        send_header(3'd3, 8'd0, 1'b1, 1'b0);
        send_graphic(8'h0c, 16'h0000, 1'b0, 1'b0);
        send_read(8'd1);
        send_read(8'd2);
        settle();
        write_config(1'b1, RM_NONE);
        send_read(8'd2);
        settle();
        write_config(1'b0, RM_HIRES_B);
        send_read(8'd2);
        send_read(8'd3);
        settle();

        // Random phases across every register setting
        for (p = 0; p < 8; p++)
        begin
            write_config(p[2] ^ p[0], 2'(p));
            run_random(110);
            settle();
        end

        if (board.errors == 0 && board.pending_pixels.size() == 0)
            $display("PASS scanline_line_buffer_engine");
        else
            $display("FAIL scanline_line_buffer_engine");
        $finish;
    end

endmodule

@@ files.f @@
design/slbe_pkg.sv
design/slbe_line_ram.sv
design/slbe_ctrl.sv
design/scanline_line_buffer_engine.sv
verif/tb_scanline_line_buffer_engine.sv
